[sv/mrm_pkg.sv]
package mrm_pkg;

  localparam int PATTERN_MAX_DEF = 8;

  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int PAT_W    = 64;
  localparam int LEN_W    = 4;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0]  LINE_FEED = 8'h0A;
  localparam logic [TICK_W-1:0]  TICK_MAX  = 16'hFFFF;

  localparam logic [PAT_W-1:0]   PATTERN_RST = 64'h0;
  localparam logic [LEN_W-1:0]   LENGTH_RST  = 4'd2;
  localparam logic [TICK_W-1:0]  LIMIT_RST   = 16'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ARM  = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_LIMIT   = 2'd2
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_AWAIT   = 3'd1,
    ST_SEARCH  = 3'd2,
    ST_SUCCESS = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_AWAIT   = 5'b00010,
    PH_SEARCH  = 5'b00100,
    PH_SUCCESS = 5'b01000,
    PH_TIMEOUT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                captured_valid;
    logic [BYTE_W-1:0]   captured_byte;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [PAT_W-1:0]     data;
  } cfg_wr_t;

  function automatic logic [STATUS_W-1:0] phase_status(input phase_t ph);
    logic [STATUS_W-1:0] s;
    case (ph)
      PH_IDLE:    s = ST_IDLE;
      PH_AWAIT:   s = ST_AWAIT;
      PH_SEARCH:  s = ST_SEARCH;
      PH_SUCCESS: s = ST_SUCCESS;
      PH_TIMEOUT: s = ST_TIMEOUT;
      default:    s = ST_IDLE;
    endcase
    return s;
  endfunction

endpackage

[sv/mrm_req_if.sv]
interface mrm_req_if import mrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [BYTE_W-1:0]   rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

[sv/mrm_rsp_if.sv]
interface mrm_rsp_if import mrm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                captured_valid;
  logic [BYTE_W-1:0]   captured_byte;

  modport source (output valid, status, captured_valid, captured_byte, input ready);
  modport sink   (input valid, status, captured_valid, captured_byte, output ready);
endinterface

[sv/mrm_in_reg.sv]
module mrm_in_reg import mrm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  held_valid,
  output item_t held_item,
  input  logic  advance
);

  // take a new word when empty or when the held one moves on
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

[sv/mrm_core.sv]
module mrm_core import mrm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  item_t   item,
  output result_t res
);

  localparam int WIN_W = 8 * PATTERN_MAX;
  localparam logic [LEN_W-1:0] PM_LEN = LEN_W'(PATTERN_MAX);

  logic [PAT_W-1:0]  pattern_bytes;
  logic [LEN_W-1:0]  pattern_length;
  logic [TICK_W-1:0] timeout_limit;

  phase_t            phase, phase_next;
  logic [WIN_W-1:0]  recent_window, recent_window_next;
  logic              pattern_seen, pattern_seen_next;
  logic [TICK_W-1:0] elapsed_ticks, elapsed_ticks_next;

  logic [WIN_W-1:0]  shifted;
  logic [LEN_W-1:0]  len_eff;
  logic [TICK_W-1:0] ticks_inc;
  logic              hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= PATTERN_RST;
      pattern_length <= LENGTH_RST;
      timeout_limit  <= LIMIT_RST;
    end else if (cfg.en) begin
      case (cfg.index)
        REG_PATTERN: pattern_bytes  <= cfg.data;
        REG_LENGTH:  pattern_length <= cfg.data[LEN_W-1:0];
        REG_LIMIT:   timeout_limit  <= cfg.data[TICK_W-1:0];
        default:     ;
      endcase
    end
  end

  // shift the byte in and compare the window against the pattern
  assign len_eff = (pattern_length > PM_LEN) ? PM_LEN : pattern_length;

  generate
    if (PATTERN_MAX > 1) begin : g_shift
      assign shifted = {recent_window[WIN_W-BYTE_W-1:0], item.rx_byte};
    end else begin : g_shift1
      assign shifted = item.rx_byte;
    end
  endgenerate

  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < len_eff &&
          shifted[8*i +: 8] != pattern_bytes[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
  end

  assign ticks_inc = (elapsed_ticks == TICK_MAX) ? elapsed_ticks
                                                 : elapsed_ticks + 1'b1;

  always_comb begin
    phase_next         = phase;
    recent_window_next = recent_window;
    pattern_seen_next  = pattern_seen;
    elapsed_ticks_next = elapsed_ticks;
    res.captured_valid = 1'b0;
    res.captured_byte  = '0;
    case (item.cmd)
      CMD_ARM: begin
        recent_window_next = '0;
        pattern_seen_next  = 1'b0;
        elapsed_ticks_next = '0;
        phase_next = (timeout_limit == '0) ? PH_TIMEOUT : PH_AWAIT;
      end
      CMD_BYTE: begin
        if (phase == PH_AWAIT) begin
          if (item.rx_byte == LINE_FEED) phase_next = PH_SEARCH;
        end else if (phase == PH_SEARCH) begin
          res.captured_valid = 1'b1;
          res.captured_byte  = item.rx_byte;
          if (!pattern_seen) begin
            recent_window_next = shifted;
            pattern_seen_next  = hit;
          end else if (item.rx_byte == LINE_FEED) begin
            phase_next = PH_SUCCESS;
          end
        end
      end
      CMD_TICK: begin
        if (phase == PH_AWAIT || phase == PH_SEARCH) begin
          elapsed_ticks_next = ticks_inc;
          if (ticks_inc >= timeout_limit) phase_next = PH_TIMEOUT;
        end
      end
      default: ;
    endcase
    res.status = phase_status(phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      recent_window <= '0;
      pattern_seen  <= 1'b0;
      elapsed_ticks <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      recent_window <= recent_window_next;
      pattern_seen  <= pattern_seen_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
  a_seen_phase: assert property (@(posedge clk) disable iff (rst)
    pattern_seen |-> (phase != PH_IDLE && phase != PH_AWAIT))
    else $error("pattern seen outside a search");
  a_cap_search: assert property (@(posedge clk) disable iff (rst)
    (fire && res.captured_valid) |-> phase == PH_SEARCH)
    else $error("capture outside search phase");
  a_arm: assert property (@(posedge clk) disable iff (rst)
    (fire && item.cmd == CMD_ARM && timeout_limit != '0) |=>
      (phase == PH_AWAIT && elapsed_ticks == '0 && !pattern_seen))
    else $error("arm did not restart the wait");
  a_ticks_mono: assert property (@(posedge clk) disable iff (rst)
    !(fire && item.cmd == CMD_ARM) |=> elapsed_ticks >= $past(elapsed_ticks))
    else $error("tick count went backwards");
`endif

endmodule

[sv/mrm_out_reg.sv]
module mrm_out_reg import mrm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  // free when empty or when the word here is taken this cycle
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

[sv/modem_reply_matcher_top.sv]
// Channel | Dir | Fields                                  | Word
// req     | in  | cmd[1:0], rx_byte[7:0]                  | one command
// rsp     | out | status[2:0], captured_valid, captured_byte[7:0] | one result
// cfg     | in  | cfg_en, cfg_index[1:0], cfg_data[63:0]  | one register write
//
// One result word per request word; a new request is taken every cycle unless rsp stalls.
// A request passes the input register, then the window compare and phase
// update feed the result register.
// Reset (rst, synchronous) returns the phase to idle and restores the
// register defaults. A stalled rsp holds the result register; the input
// register then fills and req.ready drops until rsp moves on.
module modem_reply_matcher_top import mrm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data,
  mrm_req_if.sink              req,
  mrm_rsp_if.source            rsp
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  logic    out_free;
  result_t core_res;
  result_t out_res;
  cfg_wr_t cfg;

  assign in_item.cmd     = req.cmd;
  assign in_item.rx_byte = req.rx_byte;

  assign cfg.en    = cfg_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // the held word moves into the result register when that has room
  assign advance = held_valid && out_free;

  mrm_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .advance    (advance)
  );

  // state advances exactly when a word is handed to the result register
  mrm_core #(.PATTERN_MAX(PATTERN_MAX)) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (advance),
    .item (held_item),
    .res  (core_res)
  );

  mrm_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (held_valid),
    .in_ready  (out_free),
    .in_res    (core_res),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_res   (out_res)
  );

  assign rsp.status         = out_res.status;
  assign rsp.captured_valid = out_res.captured_valid;
  assign rsp.captured_byte  = out_res.captured_byte;

endmodule

[tb/mrm_reply_checker.sv]
module mrm_reply_checker import mrm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data,
  mrm_req_if                   req,
  mrm_rsp_if                   rsp,
  output int                   fails,
  output int                   outstanding
);

  // Mirror of the matcher's registers and wait state
  logic [PAT_W-1:0]  pattern_q;
  logic [LEN_W-1:0]  length_q;
  logic [TICK_W-1:0] limit_q;
  status_t           phase_q;
  logic [PAT_W-1:0]  window_q;
  logic              seen_q;
  logic [TICK_W-1:0] ticks_q;

  result_t replies_due[$];
  result_t want;

  task automatic report_mismatch(input string msg);
    $display("[%0t] reply mismatch: %s", $realtime, msg);
    fails++;
  endtask

  // Advance the wait by one command word and give the result word it causes.
  task automatic advance_reply(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b,
                               output result_t r);
    logic [PAT_W-1:0] keep;
    int               n;
    r = '0;
    case (c)
      CMD_ARM: begin
        window_q = '0;
        seen_q   = 1'b0;
        ticks_q  = '0;
        phase_q  = (limit_q == '0) ? ST_TIMEOUT : ST_AWAIT;
      end
      CMD_BYTE: begin
        if (phase_q == ST_AWAIT) begin
          if (b == LINE_FEED) phase_q = ST_SEARCH;
        end else if (phase_q == ST_SEARCH) begin
          r.captured_valid = 1'b1;
          r.captured_byte  = b;
          if (!seen_q) begin
            window_q = {window_q[PAT_W-BYTE_W-1:0], b};
            n = (length_q > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(length_q);
            keep = (n >= PATTERN_MAX_DEF) ? '1 : ((64'd1 << (BYTE_W * n)) - 64'd1);
            if (((window_q ^ pattern_q) & keep) == '0) seen_q = 1'b1;
          end else if (b == LINE_FEED) begin
            phase_q = ST_SUCCESS;
          end
        end
      end
      CMD_TICK: begin
        if (phase_q == ST_AWAIT || phase_q == ST_SEARCH) begin
          if (ticks_q != TICK_MAX) ticks_q = ticks_q + 1'b1;
          if (ticks_q >= limit_q) phase_q = ST_TIMEOUT;
        end
      end
      default: ;
    endcase
    r.status = phase_q;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pattern_q = PATTERN_RST;
      length_q  = LENGTH_RST;
      limit_q   = LIMIT_RST;
      phase_q   = ST_IDLE;
      window_q  = '0;
      seen_q    = 1'b0;
      ticks_q   = '0;
      fails     = 0;
      replies_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_PATTERN: pattern_q = cfg_data;
          REG_LENGTH:  length_q  = cfg_data[LEN_W-1:0];
          REG_LIMIT:   limit_q   = cfg_data[TICK_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch($sformatf("result word with nothing expected (status %0d)",
                                    rsp.status));
        end else begin
          want = replies_due.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp.status, want.status));
          if (rsp.captured_valid !== want.captured_valid)
            report_mismatch($sformatf("captured_valid got %0b want %0b",
                                      rsp.captured_valid, want.captured_valid));
          if (rsp.captured_byte !== want.captured_byte)
            report_mismatch($sformatf("captured_byte got %02h want %02h",
                                      rsp.captured_byte, want.captured_byte));
        end
      end
      if (req.valid && req.ready) begin
        advance_reply(req.cmd, req.rx_byte, want);
        replies_due.push_back(want);
      end
      outstanding <= replies_due.size();
    end
  end

endmodule

[tb/testbench.sv]
module testbench;
  import mrm_pkg::*;

  // The command and register codes that the matcher leaves unused
  localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int ITEM_GOAL   = 1140;  // directed words plus the random part
  localparam int IDLE_PCT    = 27;    // chance in a hundred of a gap or a stall
  localparam int STALL_LIMIT = 2000;  // cycles without a handshake before giving up
  localparam int CALM_FROM   = 500;
  localparam int CALM_TO     = 720;

  logic                 clk;
  logic                 rst;
  logic                 cfg_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_data;

  int fails;
  int outstanding;
  int words_sent;
  int quiet_cycles;
  bit calm;  // set: neither side idles

  // What the stimulus believes the pattern registers hold
  logic [PAT_W-1:0] pattern_now;
  logic [LEN_W-1:0] length_now;

  mrm_req_if req ();
  mrm_rsp_if rsp ();

  modem_reply_matcher_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  mrm_reply_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req         (req),
    .rsp         (rsp),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random, except through the calm stretch.
  always @(posedge clk) begin
    rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Abort when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command word, with random gaps ahead of it, and hold it until taken.
  // Valid stays high from one word to the next unless a gap or a register write falls between them.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.cmd     <= c;
    req.rx_byte <= b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
  endtask

  // Write a register once the matcher has drained: drop valid, wait for the
  // last result word, then pulse the write enable for one cycle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] d);
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_en <= 1'b0;
    if (idx == REG_PATTERN) pattern_now = d;
    if (idx == REG_LENGTH)  length_now  = d[LEN_W-1:0];
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_word(CMD_BYTE, b);
  endtask

  // Send the pattern as the matcher compares it, oldest byte first.
  task automatic send_pattern();
    int n;
    n = (length_now > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(length_now);
    for (int i = n - 1; i >= 0; i--) send_byte(pattern_now[BYTE_W*i +: BYTE_W]);
  endtask

  // Slip a tick in now and then so that short limits run out mid-reply.
  task automatic maybe_tick();
    if ($urandom_range(0, 99) < 12) send_word(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_random_bytes(input int n);
    for (int i = 0; i < n; i++) begin
      maybe_tick();
      send_byte(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Timeout limit: mostly short, now and then zero, the maximum or anything at all.
  function automatic logic [TICK_W-1:0] pick_limit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5)  return '0;
    if (pick < 10) return TICK_MAX;
    if (pick < 70) return TICK_W'($urandom_range(1, 30));
    return TICK_W'($urandom_range(0, 65535));
  endfunction

  // Rewrite some of the registers; upper data bits carry junk that must be dropped.
  task automatic reconfigure();
    logic [PAT_W-1:0] d;
    int               k;
    if ($urandom_range(0, 1) == 0) begin
      d = {$urandom(), $urandom()};
      // plant line feeds in the pattern now and then
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, PATTERN_MAX_DEF - 1);
        d[BYTE_W*k +: BYTE_W] = LINE_FEED;
      end
      write_reg(REG_PATTERN, d);
    end
    if ($urandom_range(0, 1) == 0) begin
      d = {$urandom(), $urandom()};
      d[LEN_W-1:0] = ($urandom_range(0, 99) < 70) ? LEN_W'($urandom_range(1, PATTERN_MAX_DEF))
                                                  : LEN_W'($urandom_range(0, 15));
      write_reg(REG_LENGTH, d);
    end
    if ($urandom_range(0, 1) == 0) begin
      d = {$urandom(), $urandom()};
      d[TICK_W-1:0] = pick_limit();
      write_reg(REG_LIMIT, d);
    end
  endtask

  // A well-formed reply: arm, line noise, line feed, filler, the pattern,
  // a short tail and usually the closing line feed. Ticks fall anywhere but inside the pattern.
  task automatic send_reply();
    send_word(CMD_ARM, BYTE_W'($urandom_range(0, 255)));
    send_random_bytes($urandom_range(0, 3));
    maybe_tick();
    send_byte(LINE_FEED);
    // lower or raise the limit while the wait is open
    if ($urandom_range(0, 99) < 5) write_reg(REG_LIMIT, {48'h0, pick_limit()});
    send_random_bytes($urandom_range(0, 4));
    send_pattern();
    send_random_bytes($urandom_range(0, 3));
    maybe_tick();
    if ($urandom_range(0, 99) < 85) send_byte(LINE_FEED);
  endtask

  // Noise: any command, including the unused one, bytes with the odd line feed.
  task automatic send_noise(input int n);
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 7) == 0) ? LINE_FEED : BYTE_W'($urandom_range(0, 255));
      send_word(CMD_W'($urandom_range(0, 3)), b);
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_en      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    req.valid   = 1'b0;
    req.cmd     = '0;
    req.rx_byte = '0;
    pattern_now = PATTERN_RST;
    length_now  = LENGTH_RST;
    words_sent  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Words while idle and the unused command: all ignored.
    send_byte(8'h41);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_SPARE, 8'hFF);

    // Plain reply: noise before the line, then the text, then the closing line feed.
    write_reg(REG_PATTERN, 64'h4F4B);
    write_reg(REG_SPARE, '1);
    send_word(CMD_ARM, 8'h00);
    send_byte(8'h41);
    send_byte(LINE_FEED);
    send_byte(8'h4F);
    send_byte(8'h4B);
    send_byte(8'h00);
    send_byte(LINE_FEED);
    send_byte(8'hFF);

    // A line feed that completes the pattern must not end the wait.
    write_reg(REG_LENGTH, 64'd1);
    write_reg(REG_PATTERN, {56'h0, LINE_FEED});
    send_word(CMD_ARM, 8'hFF);
    send_byte(LINE_FEED);
    send_byte(LINE_FEED);
    send_byte(LINE_FEED);

    // Zero limit times out on the arm itself.
    write_reg(REG_LIMIT, 64'd0);
    send_word(CMD_ARM, 8'h00);

    // Limit lowered during a wait: the next tick times out.
    write_reg(REG_LIMIT, 64'd3);
    write_reg(REG_LENGTH, 64'd8);
    write_reg(REG_PATTERN, '1);
    send_word(CMD_ARM, 8'h00);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_TICK, 8'h00);
    write_reg(REG_LIMIT, {48'h0, TICK_MAX});
    write_reg(REG_LIMIT, 64'd1);
    send_word(CMD_TICK, 8'hFF);

    // Empty pattern matches on the first captured byte.
    write_reg(REG_LENGTH, 64'd0);
    send_word(CMD_ARM, 8'h00);
    send_byte(LINE_FEED);
    send_byte(8'hFF);
    send_byte(LINE_FEED);

    // Oversized length and a zero pattern: matches against the cleared window.
    write_reg(REG_LENGTH, 64'd15);
    write_reg(REG_PATTERN, 64'd0);
    write_reg(REG_LIMIT, 64'd40);
    send_word(CMD_ARM, 8'h00);
    send_byte(LINE_FEED);
    send_byte(8'h00);
    send_byte(LINE_FEED);

    // Random part: mostly well-formed replies, the rest noise and fresh settings.
    while (words_sent < ITEM_GOAL) begin
      calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);
      if ($urandom_range(0, 9) < 3) reconfigure();
      if ($urandom_range(0, 9) < 7) send_reply();
      else                          send_noise($urandom_range(1, 8));
    end

    // Drain: drop valid, wait out the last result word and the pipeline.
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
